[rtl/chdc_pkg.sv]
// ----------------------------------------------------------------------------
// Chunk DC removal package
// Widths, register indexes, control bundles and saturation helpers shared by
// the chunk DC removal and high-pass biquad block.
// ----------------------------------------------------------------------------
package chdc_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SUM_W         = 34;
    localparam int MEAN_W        = 25;
    localparam int X_W           = 26;
    localparam int Y_W           = 26;
    localparam int COEF_W        = 32;
    localparam int DLY_W         = 40;
    localparam int PROD_W        = COEF_W + X_W;
    localparam int DIV_N_W       = SUM_W + 8;
    localparam int LEN_W         = 18;
    localparam int LEN_RESET     = 72000;
    localparam int CHUNK_MAX_DEF = 131072;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;
    localparam int OUT_TDATA_W   = 32;

    typedef enum logic [2:0] {
        REG_B0  = 3'd0,
        REG_B1  = 3'd1,
        REG_B2  = 3'd2,
        REG_A1  = 3'd3,
        REG_A2  = 3'd4,
        REG_EN  = 3'd5,
        REG_LEN = 3'd6
    } t_reg;

    // Step strobes from the sequencer to the filter datapath.
    typedef struct packed {
        logic en;
        logic ld_x;
        logic ld_p;
        logic ld_y;
        logic ld_q;
        logic ld_d;
        logic clr_d;
    } t_bq_ctrl;

    function automatic logic signed [Y_W-1:0] sat_y(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (Y_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return Y_W'(hi);
        end else if (v < lo) begin
            return Y_W'(lo);
        end
        return Y_W'(v);
    endfunction

    function automatic logic signed [DLY_W-1:0] sat_d(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DLY_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return DLY_W'(hi);
        end else if (v < lo) begin
            return DLY_W'(lo);
        end
        return DLY_W'(v);
    endfunction

endpackage

[rtl/chdc_store.sv]
// ----------------------------------------------------------------------------
// Chunk sample store
// Single-port synchronous sample memory with a registered read.
// ----------------------------------------------------------------------------
module chdc_store #(
    parameter int DEPTH = chdc_pkg::CHUNK_MAX_DEF,
    parameter int AW    = 17
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_addr,
    input  logic [chdc_pkg::SAMPLE_W-1:0] i_wdata,
    output logic [chdc_pkg::SAMPLE_W-1:0] o_rdata
);
    import chdc_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/chdc_div.sv]
// ----------------------------------------------------------------------------
// Chunk mean divider
// Restoring divider, one quotient bit per cycle, giving the chunk mean with
// eight fraction bits, truncated toward zero.
// ----------------------------------------------------------------------------
module chdc_div #(
    parameter int CW = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_neg,
    input  logic [chdc_pkg::DIV_N_W-1:0]       i_dividend,
    input  logic [CW-1:0]                      i_divisor,
    output logic                               o_done,
    output logic signed [chdc_pkg::MEAN_W-1:0] o_mean
);
    import chdc_pkg::*;

    localparam int STEP_W = $clog2(DIV_N_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_den;
    logic [DIV_N_W-1:0] r_q;
    logic              r_neg;
    logic [CW:0]       trial;
    logic              ge;
    logic [MEAN_W-1:0] mag;

    assign trial = {r_rem, r_q[DIV_N_W-1]};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of r_q while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_N_W-2:0], ge};
            r_rem <= ge ? CW'(trial - {1'b0, r_den}) : CW'(trial);
        end
    end

    assign mag    = r_q[MEAN_W-1:0];
    assign o_done = r_done;
    assign o_mean = r_neg ? -$signed(mag) : $signed(mag);

endmodule

[rtl/chdc_biquad.sv]
// ----------------------------------------------------------------------------
// Chunk biquad datapath
// Mean removal and a transposed direct form II biquad, one multiply rank per
// step, with saturating fixed-point delay state.
// ----------------------------------------------------------------------------
module chdc_biquad (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  chdc_pkg::t_bq_ctrl                 i_ctrl,
    input  logic [chdc_pkg::SAMPLE_W-1:0]      i_rdata,
    input  logic signed [chdc_pkg::MEAN_W-1:0] i_mean,
    input  logic signed [chdc_pkg::COEF_W-1:0] i_b0,
    input  logic signed [chdc_pkg::COEF_W-1:0] i_b1,
    input  logic signed [chdc_pkg::COEF_W-1:0] i_b2,
    input  logic signed [chdc_pkg::COEF_W-1:0] i_a1,
    input  logic signed [chdc_pkg::COEF_W-1:0] i_a2,
    output logic signed [chdc_pkg::Y_W-1:0]    o_y
);
    import chdc_pkg::*;

    logic signed [X_W-1:0]    r_x;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [PROD_W-1:0] r_q1, r_q2;
    logic signed [Y_W-1:0]    r_y;
    logic signed [DLY_W-1:0]  r_d1, r_d2;
    logic signed [X_W-1:0]    x_new;
    logic signed [63:0]       acc0, acc1, acc2;

    // Sample in Q2.23 of full scale minus the mean with 8 fraction bits.
    assign x_new = $signed({{(X_W - SAMPLE_W - 8){i_rdata[SAMPLE_W-1]}}, i_rdata, 8'b0})
                 - X_W'(i_mean);

    assign acc0 = 64'(r_p0) + (64'(r_d1) <<< 20);
    assign acc1 = 64'(r_p1) - 64'(r_q1) + (64'(r_d2) <<< 20);
    assign acc2 = 64'(r_p2) - 64'(r_q2);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_x) begin
            r_x <= x_new;
        end
        if (i_ctrl.ld_p) begin
            r_p0 <= i_b0 * r_x;
            r_p1 <= i_b1 * r_x;
            r_p2 <= i_b2 * r_x;
        end
        if (i_ctrl.ld_y) begin
            r_y <= i_ctrl.en ? sat_y(acc0 >>> 28) : sat_y(64'(r_x));
        end
        if (i_ctrl.ld_q) begin
            r_q1 <= i_a1 * r_y;
            r_q2 <= i_a2 * r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctrl.clr_d) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_ctrl.ld_d) begin
            r_d1 <= sat_d(acc1 >>> 20);
            r_d2 <= sat_d(acc2 >>> 20);
        end
    end

    assign o_y = r_y;

endmodule

[rtl/chunk_dc_removal_biquad_highpass.sv]
// ----------------------------------------------------------------------------
// Chunk DC removal and high-pass biquad
// Loads a chunk of samples into a sample memory, takes its mean, then plays
// the chunk back mean-removed and optionally high-pass filtered.
//
//  Channel   Direction  Payload
//  s stream  in         tdata[15:0] sample, tuser mode (0 load, 1 emit)
//  m stream  out        tdata[25:0] filtered_sample, tlast last_of_chunk
//  APB       in/out     coef_b0..coef_a2, filter_enable, chunk_length
//
// A load word is taken while idle; the load that closes a chunk then waits in
// S_DIV for the mean from the one-bit-per-cycle divider.
// An emit word runs memory read, then S_X, S_MA, S_Y, S_MB, S_D, S_OUT with the
// filter on, one multiply rank per step through the biquad; S_X, S_Y, S_OUT off.
// Reset is synchronous and returns the block to loading with the sums cleared.
// A result waiting on the output does not block new words until the next
// result is ready; that one then holds until the output register frees.
// ----------------------------------------------------------------------------
module chunk_dc_removal_biquad_highpass #(
    parameter int CHUNK_MAX = chdc_pkg::CHUNK_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [chdc_pkg::SAMPLE_W-1:0]       i_s_tdata,  // [15:0] sample
    input  logic                                i_s_tuser,  // [0] mode
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [chdc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // [25:0] filtered_sample
    output logic                                o_m_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [chdc_pkg::APB_AW-1:0]         paddr,
    input  logic [chdc_pkg::APB_DW-1:0]         pwdata,
    output logic [chdc_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import chdc_pkg::*;

    localparam int AW = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
    localparam int CW = $clog2(CHUNK_MAX + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV  = 8'b0000_0010,
        S_X    = 8'b0000_0100,
        S_MA   = 8'b0000_1000,
        S_Y    = 8'b0001_0000,
        S_MB   = 8'b0010_0000,
        S_D    = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic signed [MEAN_W-1:0] r_mean, n_mean;
    logic                     r_emitting, n_emitting;
    logic                     r_out_valid, n_out_valid;
    logic signed [Y_W-1:0]    r_out_y, n_out_y;
    logic                     r_out_last, n_out_last;

    logic signed [COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;
    logic                     r_en;
    logic [LEN_W-1:0]         r_len;

    logic [CW-1:0]            eff_len;
    logic                     cnt_last;
    logic                     in_acc;
    logic                     mem_we, mem_re;
    logic [SAMPLE_W-1:0]      mem_rdata;
    logic                     div_start, div_done, div_neg;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [MEAN_W-1:0] div_mean;
    t_bq_ctrl                 bq_ctrl;
    logic signed [Y_W-1:0]    bq_y;
    logic [2:0]               reg_idx;
    logic                     cfg_wr;

    // ---------------- configuration port ----------------
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0  <= '0;
            r_b1  <= '0;
            r_b2  <= '0;
            r_a1  <= '0;
            r_a2  <= '0;
            r_en  <= 1'b0;
            r_len <= LEN_W'(LEN_RESET);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_B0:  r_b0  <= $signed(pwdata);
                REG_B1:  r_b1  <= $signed(pwdata);
                REG_B2:  r_b2  <= $signed(pwdata);
                REG_A1:  r_a1  <= $signed(pwdata);
                REG_A2:  r_a2  <= $signed(pwdata);
                REG_EN:  r_en  <= pwdata[0];
                REG_LEN: r_len <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_B0:  prdata = r_b0;
            REG_B1:  prdata = r_b1;
            REG_B2:  prdata = r_b2;
            REG_A1:  prdata = r_a1;
            REG_A2:  prdata = r_a2;
            REG_EN:  prdata = {{(APB_DW - 1){1'b0}}, r_en};
            REG_LEN: prdata = {{(APB_DW - LEN_W){1'b0}}, r_len};
            default: prdata = '0;
        endcase
    end

    // Chunk length clamped to between 2 and the store depth CHUNK_MAX.
    always_comb begin
        if (r_len < LEN_W'(2)) begin
            eff_len = CW'(2);
        end else if (32'(r_len) > 32'(CHUNK_MAX)) begin
            eff_len = CW'(CHUNK_MAX);
        end else begin
            eff_len = CW'(r_len);
        end
    end

    assign cnt_last = ((CW + 1)'(r_count) + 1'b1) >= (CW + 1)'(eff_len);

    // ---------------- sequencer ----------------
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid & o_s_tready;
    assign mem_we     = in_acc & ~i_s_tuser & ~r_emitting;
    assign mem_re     = in_acc & i_s_tuser & r_emitting;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_mean      = r_mean;
        n_emitting  = r_emitting;
        n_out_valid = r_out_valid;
        n_out_y     = r_out_y;
        n_out_last  = r_out_last;
        div_start   = 1'b0;
        bq_ctrl     = '0;
        bq_ctrl.en  = r_en;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (mem_we) begin
                    n_sum = r_sum + SUM_W'($signed(i_s_tdata));
                    if (cnt_last) begin
                        n_count       = '0;
                        div_start     = 1'b1;
                        bq_ctrl.clr_d = 1'b1;
                        n_state       = S_DIV;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end else if (mem_re) begin
                    n_state = S_X;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_mean     = div_mean;
                    n_emitting = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_X: begin
                bq_ctrl.ld_x = 1'b1;
                n_state      = r_en ? S_MA : S_Y;
            end
            S_MA: begin
                bq_ctrl.ld_p = 1'b1;
                n_state      = S_Y;
            end
            S_Y: begin
                bq_ctrl.ld_y = 1'b1;
                n_state      = r_en ? S_MB : S_OUT;
            end
            S_MB: begin
                bq_ctrl.ld_q = 1'b1;
                n_state      = S_D;
            end
            S_D: begin
                bq_ctrl.ld_d = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_y     = bq_y;
                    n_out_last  = cnt_last;
                    n_state     = S_IDLE;
                    if (cnt_last) begin
                        n_count       = '0;
                        n_sum         = '0;
                        n_emitting    = 1'b0;
                        bq_ctrl.clr_d = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_mean      <= '0;
            r_emitting  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_mean      <= n_mean;
            r_emitting  <= n_emitting;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_y <= n_out_y;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - Y_W){1'b0}}, r_out_y};
    assign o_m_tlast  = r_out_last;

    // ---------------- units ----------------
    chdc_store #(
        .DEPTH (CHUNK_MAX),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (r_count[AW-1:0]),
        .i_wdata (i_s_tdata),
        .o_rdata (mem_rdata)
    );

    assign div_neg = n_sum[SUM_W-1];
    assign sum_mag = div_neg ? SUM_W'(-n_sum) : SUM_W'(n_sum);

    chdc_div #(
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_neg      (div_neg),
        .i_dividend ({sum_mag, 8'b0}),
        .i_divisor  (eff_len),
        .o_done     (div_done),
        .o_mean     (div_mean)
    );

    chdc_biquad u_biquad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (bq_ctrl),
        .i_rdata (mem_rdata),
        .i_mean  (r_mean),
        .i_b0    (r_b0),
        .i_b1    (r_b1),
        .i_b2    (r_b2),
        .i_a1    (r_a1),
        .i_a2    (r_a2),
        .o_y     (bq_y)
    );

    // ---------------- assertions ----------------
    a_count_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) < CHUNK_MAX)
        else $error("sample counter ran past the store depth");

    a_emit_starts_on_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_emitting) |-> $past(div_done))
        else $error("playback began without a finished mean");

    a_emit_ends_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_emitting) |-> ($past(r_state == S_OUT) && r_out_valid && r_out_last))
        else $error("playback ended without a last result");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the mean step");

    a_read_only_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_X) |-> (r_emitting && $past(mem_re)))
        else $error("filter step entered without a playback read");

endmodule
